>>> rtl/core/vc_pkg.sv
// Shared types and constants for the varint codec.
// Holds opcode, result kind, controller state and the command/status structs.
// No dependencies.
package vc_pkg;

  localparam int GROUP_BITS = 7;
  localparam int VALUE_W    = 64;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 4;
  localparam int SHIFT_W    = 7;

  localparam logic [BYTE_W-1:0] DATA_MASK  = 8'h7F;
  localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
  localparam logic [CNT_W-1:0]  LIMIT_INT  = 4'd5;
  localparam logic [CNT_W-1:0]  LIMIT_LONG = 4'd10;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_ENC  = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic dec_step;   // take the input byte into the decoder
    logic enc_load;   // latch the input value into the encoder
    logic enc_shift;  // emit one encoded byte and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dec_done;   // current input byte completes a value or an error
    logic enc_last;   // the encoder holds its final group
  } sts_t;

endpackage

>>> rtl/core/vc_dp.sv
// Datapath of the varint codec: decode accumulator, encode shift register
// and the output payload register. Depends on vc_pkg.
module vc_dp
  import vc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic [1:0]              s_tuser,
  input  logic [BYTE_W+VALUE_W-1:0] s_tdata,
  output sts_t                    sts,
  output logic [BYTE_W+VALUE_W-1:0] m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);

  logic [VALUE_W-1:0] acc, acc_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [VALUE_W-1:0] enc_val;

  logic [BYTE_W-1:0]  out_byte;
  logic [VALUE_W-1:0] out_value;
  kind_t              out_kind;
  logic               out_last;

  logic               is_long;
  logic [BYTE_W-1:0]  in_byte;
  logic [VALUE_W-1:0] in_value;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   cnt_inc;
  logic [SHIFT_W-1:0] sh;
  logic [VALUE_W-1:0] acc_merged;
  logic [VALUE_W-1:0] dec_value;
  logic               cont;
  logic               enc_more;
  logic [BYTE_W-1:0]  enc_byte;

  assign is_long  = s_tuser[1];
  assign in_byte  = s_tdata[BYTE_W-1:0];
  assign in_value = s_tdata[BYTE_W+VALUE_W-1:BYTE_W];

  // Decode: place the 7 data bits at 7*count; groups past bit 63 fall off
  assign limit      = is_long ? LIMIT_LONG : LIMIT_INT;
  assign cnt_inc    = cnt + CNT_W'(1);
  assign sh         = SHIFT_W'(cnt) * SHIFT_W'(GROUP_BITS);
  assign acc_merged = acc | (VALUE_W'(in_byte & DATA_MASK) << sh);
  assign dec_value  = is_long ? acc_merged : {32'd0, acc_merged[31:0]};
  assign cont       = (in_byte & CONT_BIT) != '0;

  assign sts.dec_done = !cont || (cnt_inc >= limit);

  always_comb begin
    acc_next = acc;
    cnt_next = cnt;
    if (cmd.dec_step) begin
      if (sts.dec_done) begin
        acc_next = '0;
        cnt_next = '0;
      end else begin
        acc_next = acc_merged;
        cnt_next = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  // Encode: low group out first, continuation set while upper bits remain
  assign enc_more     = enc_val[VALUE_W-1:GROUP_BITS] != '0;
  assign enc_byte     = {enc_more, enc_val[GROUP_BITS-1:0]};
  assign sts.enc_last = !enc_more;

  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      enc_val <= is_long ? in_value : {32'd0, in_value[31:0]};
    end else if (cmd.enc_shift) begin
      enc_val <= enc_val >> GROUP_BITS;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.enc_shift) begin
      out_byte  <= enc_byte;
      out_value <= '0;
      out_kind  <= KIND_BYTE;
      out_last  <= !enc_more;
    end else if (cmd.dec_step && sts.dec_done) begin
      out_byte  <= '0;
      out_value <= cont ? '0 : dec_value;
      out_kind  <= cont ? KIND_ERROR : KIND_VALUE;
      out_last  <= 1'b1;
    end
  end

  assign m_tdata = {out_value, out_byte};
  assign m_tuser = 2'(out_kind);
  assign m_tlast = out_last;

endmodule

>>> rtl/core/vc_ctrl.sv
// Controller of the varint codec: input handshake, encode sequencing and
// output valid. Depends on vc_pkg.
module vc_ctrl
  import vc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic opcode,
  input  logic m_tready,
  input  sts_t sts,
  output logic s_tready,
  output logic m_tvalid,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    s_tready       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = out_free;
        if (accept) begin
          if (opcode_t'(opcode) == OP_DECODE) begin
            cmd.dec_step = 1'b1;
            if (sts.dec_done) begin
              out_valid_next = 1'b1;
            end
          end else begin
            cmd.enc_load = 1'b1;
            state_next   = ST_ENC;
          end
        end
      end
      ST_ENC: begin
        if (out_free) begin
          cmd.enc_shift  = 1'b1;
          out_valid_next = 1'b1;
          if (sts.enc_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/varint_codec.sv
// Top level of the unsigned LEB128 varint/varlong codec.
// Instantiates vc_ctrl and vc_dp; depends on vc_pkg.
//
// Decoding takes one received byte per transfer and completes a value when a
// byte arrives with its continuation bit clear; a 5th byte (32-bit mode) or
// 10th byte (64-bit mode) that still continues yields one error result and
// clears the decoder. A new decode byte can be taken every cycle as long as
// the output register is free or being drained. Encoding takes a whole value
// and emits 1 to 10 bytes, the last one flagged by tlast; it first loads the
// encode shift register, then emits one byte per cycle through the single
// output register while the output does not stall. The decoder state is kept
// across encodes, so encodes may be interleaved with a partial decode.
module varint_codec
  import vc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [BYTE_W+VALUE_W-1:0] s_tdata,   // in_byte[7:0], in_value[71:8]
  input  logic [1:0]                s_tuser,   // opcode[0], is_long[1]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [BYTE_W+VALUE_W-1:0] m_tdata,   // out_byte[7:0], out_value[71:8]
  output logic [1:0]                m_tuser,   // kind[1:0]
  output logic                      m_tlast
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing: handshakes, encode byte loop, output valid
  vc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .opcode   (s_tuser[0]),
    .m_tready (m_tready),
    .sts      (sts),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  // Accumulator, encode shift register and output payload
  vc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

`ifndef SYNTHESIS
  // Hold off new input while an encode is running
  a_enc_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.enc_load |=> !s_tready)
    else $error("input accepted while encoding");

  // Decode and error results are single, final and carry no byte
  a_dec_result_form: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == 2'(KIND_VALUE) || m_tuser == 2'(KIND_ERROR)))
      |-> (m_tlast && m_tdata[BYTE_W-1:0] == '0))
    else $error("malformed decode result");

  // A completing decode byte shows up at the output in the next cycle
  a_dec_emits: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0] == 1'(OP_DECODE) && sts.dec_done)
      |=> (m_tvalid && m_tuser != 2'(KIND_BYTE)))
    else $error("decode result lost");
`endif

endmodule
